// ----- hw/rtl/dwtdb6_pkg.sv -----
// ---------------------------------------------------------------------------
// dwtdb6_pkg
// Shared constants, coefficient tables and types of the db6 analysis bank.
// ---------------------------------------------------------------------------
package dwtdb6_pkg;

   localparam int TAPS       = 12;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 15;
   localparam int OUT_W      = 18;
   localparam int FRAC_SHIFT = COEF_W - 1;
   localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
   localparam int OUT_MAX    = (1 << (OUT_W - 1)) - 1;
   localparam int OUT_MIN    = -(1 << (OUT_W - 1));

   localparam int FLUSH_LEN   = TAPS - 2;
   localparam int FLUSH_CNT_W = $clog2(TAPS);

   localparam int PROD_W  = SAMPLE_W + COEF_W;
   localparam int SUM_W   = PROD_W + $clog2(TAPS);
   localparam int MIN_ACC = OUT_W + FRAC_SHIFT + 2;
   localparam int ACC_W   = (SUM_W > MIN_ACC) ? SUM_W : MIN_ACC;
   localparam int QUO_W   = ACC_W - FRAC_SHIFT;

   localparam int GRP  = 4;
   localparam int NGRP = (TAPS + GRP - 1) / GRP;

   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

   localparam int COEF_TBL = 32;

   // db6 low-pass taps in Q1.14, zero past the twelfth tap
   localparam logic signed [COEF_W-1:0] LO_COEF [COEF_TBL] = '{
      -15'sd18,   15'sd79,    15'sd10,   -15'sd518,
      15'sd451,   15'sd1597,  -15'sd2127, -15'sd3708,
      15'sd5166,  15'sd12306, 15'sd8104,  15'sd1827,
      15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0,
      15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0,
      15'sd0, 15'sd0, 15'sd0, 15'sd0
   };

   function automatic logic signed [COEF_W-1:0] lo_tap(input int j);
      return LO_COEF[j];
   endfunction

   // quadrature mirror: odd taps keep sign, even taps flip it
   function automatic logic signed [COEF_W-1:0] hi_tap(input int j);
      logic signed [COEF_W-1:0] c;
      c = LO_COEF[TAPS - 1 - j];
      return (j % 2 == 1) ? c : -c;
   endfunction

   typedef struct packed {
      logic                       vld;
      logic                       last;
      logic signed [SAMPLE_W-1:0] sample;
   } fq_head_type;

   typedef struct packed {
      logic pop;
      logic flushing;
   } seq_stat_type;

   typedef struct packed {
      logic vld;
      logic last;
   } issue_type;

endpackage

// ----- hw/rtl/dwtdb6_if.sv -----
// ---------------------------------------------------------------------------
// dwtdb6 channel interfaces
// Sample request channel and coefficient response channel, valid/ready.
// ---------------------------------------------------------------------------
interface dwtdb6_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dwtdb6_pkg::SAMPLE_W-1:0] sample;
   logic                                  last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface dwtdb6_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [dwtdb6_pkg::OUT_W-1:0] approx;
   logic signed [dwtdb6_pkg::OUT_W-1:0] detail;
   logic                               last_output;

   modport source (output valid, output approx, output detail, output last_output,
                   input ready);
   modport sink   (input valid, input approx, input detail, input last_output,
                   output ready);
endinterface

// ----- hw/rtl/dwt_analysis_decimating_filter_bank.sv -----
// ---------------------------------------------------------------------------
// dwt_analysis_decimating_filter_bank
// One level of 12-tap db6 wavelet analysis with decimation by two.
//
// Channel   Dir  Beat contents
// req_chan  in   sample (Q4.11), last_sample
// rsp_chan  out  approx, detail (Q6.11, saturated), last_output
//
// A stream sample is taken every cycle unless a stalled result or the tail
// flush holds the sequencer; one result per two samples. After a last_sample
// beat the sequencer feeds 10 zeros (5 tail results) and pops no queue entry
// meanwhile; the 4-entry queue absorbs input beats during that time.
// From queue pop a result passes the product, group sum, total and
// round/saturate registers. A stalled result holds the whole pipeline.
// Synchronous reset clears the queue, delay line, phase and valid bits.
// ---------------------------------------------------------------------------
module dwt_analysis_decimating_filter_bank (
   input  logic         clock,
   input  logic         reset,
   dwtdb6_req_if.sink   req_chan,
   dwtdb6_rsp_if.source rsp_chan
);
   import dwtdb6_pkg::*;

   fq_head_type                head;
   seq_stat_type               stat;
   issue_type                  iss;
   logic                       adv;
   logic signed [SAMPLE_W-1:0] win [TAPS];

   dwtdb6_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .stat     (stat),
      .head     (head)
   );

   dwtdb6_seq u_seq (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .head  (head),
      .stat  (stat),
      .iss   (iss),
      .win   (win)
   );

   dwtdb6_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .iss      (iss),
      .win      (win),
      .adv      (adv),
      .rsp_chan (rsp_chan)
   );

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> head.vld)
      else $error("queue popped while empty");

   a_no_pop_in_flush: assert property (@(posedge clock) disable iff (reset)
      stat.flushing |-> !stat.pop)
      else $error("queue popped during tail flush");

   a_issue_on_adv: assert property (@(posedge clock) disable iff (reset)
      iss.vld |-> adv)
      else $error("window issued into stalled pipeline");

   a_last_is_issue: assert property (@(posedge clock) disable iff (reset)
      iss.last |-> iss.vld)
      else $error("last flag without issued window");

endmodule

// ----- hw/rtl/dwtdb6_front.sv -----
// ---------------------------------------------------------------------------
// dwtdb6_front
// Input queue: takes request beats and presents the oldest to the sequencer.
// ---------------------------------------------------------------------------
module dwtdb6_front (
   input  logic                     clock,
   input  logic                     reset,
   dwtdb6_req_if.sink               req_chan,
   input  dwtdb6_pkg::seq_stat_type stat,
   output dwtdb6_pkg::fq_head_type  head
);
   import dwtdb6_pkg::*;

   logic signed [SAMPLE_W-1:0] smp_mem_ff [FQ_DEPTH];
   logic                       last_mem_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                       push;
   logic                       pop;

   assign req_chan.ready = (cnt_ff != FQ_CNT_W'(FQ_DEPTH));
   assign push = req_chan.valid && req_chan.ready;
   assign pop  = stat.pop;

   assign head.vld    = (cnt_ff != '0);
   assign head.sample = smp_mem_ff[rd_ptr_ff];
   assign head.last   = last_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + FQ_CNT_W'(push) - FQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         smp_mem_ff[wr_ptr_ff]  <= req_chan.sample;
         last_mem_ff[wr_ptr_ff] <= req_chan.last_sample;
      end
   end

endmodule

// ----- hw/rtl/dwtdb6_seq.sv -----
// ---------------------------------------------------------------------------
// dwtdb6_seq
// Delay line, phase and tail flush sequencer; issues even-index windows.
// ---------------------------------------------------------------------------
module dwtdb6_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  dwtdb6_pkg::fq_head_type     head,
   output dwtdb6_pkg::seq_stat_type    stat,
   output dwtdb6_pkg::issue_type       iss,
   output logic signed [dwtdb6_pkg::SAMPLE_W-1:0] win [dwtdb6_pkg::TAPS]
);
   import dwtdb6_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_FLUSH = 2'b10
   } seq_state_type;

   seq_state_type              state_ff, state_in;
   logic signed [SAMPLE_W-1:0] dl_ff [TAPS-1];
   logic signed [SAMPLE_W-1:0] dl_in [TAPS-1];
   logic                       even_ff, even_in;
   logic [FLUSH_CNT_W-1:0]     rem_ff, rem_in;
   logic signed [SAMPLE_W-1:0] cur;
   logic                       step;
   logic                       clear;

   always_comb begin
      cur = (state_ff == ST_FLUSH) ? '0 : head.sample;
      win[0] = cur;
      for (int j = 1; j < TAPS; j++) begin
         win[j] = dl_ff[j-1];
      end
   end

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      even_in       = even_ff;
      dl_in         = dl_ff;
      clear         = 1'b0;
      stat.pop      = 1'b0;
      stat.flushing = (state_ff == ST_FLUSH);
      iss.vld       = 1'b0;
      iss.last      = 1'b0;
      step          = adv && ((state_ff == ST_FLUSH) || head.vld);

      if (step) begin
         iss.vld = even_ff;
         even_in = !even_ff;
         for (int j = TAPS - 2; j > 0; j--) begin
            dl_in[j] = dl_ff[j-1];
         end
         dl_in[0] = cur;

         unique case (state_ff)
            ST_RUN: begin
               stat.pop = 1'b1;
               if (head.last) begin
                  if (FLUSH_LEN == 0) begin
                     iss.last = even_ff;
                     clear    = 1'b1;
                  end else begin
                     // flag here only if no even index follows in the tail
                     iss.last = even_ff && (FLUSH_LEN < 2);
                     rem_in   = FLUSH_CNT_W'(FLUSH_LEN);
                     state_in = ST_FLUSH;
                  end
               end
            end
            ST_FLUSH: begin
               iss.last = even_ff && (rem_ff <= FLUSH_CNT_W'(2));
               rem_in   = rem_ff - 1'b1;
               if (rem_ff == FLUSH_CNT_W'(1)) begin
                  clear    = 1'b1;
                  state_in = ST_RUN;
               end
            end
            default: begin
               state_in = ST_RUN;
            end
         endcase
      end

      if (clear) begin
         even_in = 1'b1;
         for (int j = 0; j < TAPS - 1; j++) begin
            dl_in[j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         rem_ff   <= '0;
         even_ff  <= 1'b1;
         for (int j = 0; j < TAPS - 1; j++) begin
            dl_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         even_ff  <= even_in;
         dl_ff    <= dl_in;
      end
   end

endmodule

// ----- hw/rtl/dwtdb6_mac.sv -----
// ---------------------------------------------------------------------------
// dwtdb6_mac
// Four-stage filter pipeline: products, group sums, total, round/saturate.
// ---------------------------------------------------------------------------
module dwtdb6_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  dwtdb6_pkg::issue_type iss,
   input  logic signed [dwtdb6_pkg::SAMPLE_W-1:0] win [dwtdb6_pkg::TAPS],
   output logic                  adv,
   dwtdb6_rsp_if.source          rsp_chan
);
   import dwtdb6_pkg::*;

   logic signed [PROD_W-1:0] p_lo_ff [TAPS];
   logic signed [PROD_W-1:0] p_hi_ff [TAPS];
   logic signed [PROD_W-1:0] p_lo_in [TAPS];
   logic signed [PROD_W-1:0] p_hi_in [TAPS];
   logic                     vld1_ff, last1_ff;

   logic signed [ACC_W-1:0]  g_lo_ff [NGRP];
   logic signed [ACC_W-1:0]  g_hi_ff [NGRP];
   logic signed [ACC_W-1:0]  g_lo_in [NGRP];
   logic signed [ACC_W-1:0]  g_hi_in [NGRP];
   logic                     vld2_ff, last2_ff;

   logic signed [ACC_W-1:0]  a_lo_ff, a_hi_ff, a_lo_in, a_hi_in;
   logic                     vld3_ff, last3_ff;

   logic signed [OUT_W-1:0]  o_lo_ff, o_hi_ff, o_lo_in, o_hi_in;
   logic                     out_vld_ff, out_last_ff;

   // hold every stage while the output register is full and not taken
   assign adv = !out_vld_ff || rsp_chan.ready;

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.approx      = o_lo_ff;
   assign rsp_chan.detail      = o_hi_ff;
   assign rsp_chan.last_output = out_last_ff;

   function automatic logic signed [OUT_W-1:0] scale_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] biased;
      logic signed [QUO_W-1:0] quo;
      logic signed [OUT_W-1:0] res;
      biased = acc + ACC_W'(ROUND_BIAS);
      quo    = QUO_W'(biased >>> FRAC_SHIFT);
      if (quo > QUO_W'(OUT_MAX)) begin
         res = OUT_W'(OUT_MAX);
      end else if (quo < QUO_W'(OUT_MIN)) begin
         res = OUT_W'(OUT_MIN);
      end else begin
         res = quo[OUT_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      for (int j = 0; j < TAPS; j++) begin
         p_lo_in[j] = PROD_W'(win[j]) * PROD_W'(lo_tap(j));
         p_hi_in[j] = PROD_W'(win[j]) * PROD_W'(hi_tap(j));
      end
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         g_lo_in[g] = '0;
         g_hi_in[g] = '0;
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < TAPS) begin
               g_lo_in[g] = g_lo_in[g] + ACC_W'(p_lo_ff[g * GRP + k]);
               g_hi_in[g] = g_hi_in[g] + ACC_W'(p_hi_ff[g * GRP + k]);
            end
         end
      end
   end

   always_comb begin
      a_lo_in = '0;
      a_hi_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         a_lo_in = a_lo_in + g_lo_ff[g];
         a_hi_in = a_hi_in + g_hi_ff[g];
      end
      o_lo_in = scale_sat(a_lo_ff);
      o_hi_in = scale_sat(a_hi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff    <= iss.vld;
         vld2_ff    <= vld1_ff;
         vld3_ff    <= vld2_ff;
         out_vld_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_lo_ff     <= p_lo_in;
         p_hi_ff     <= p_hi_in;
         last1_ff    <= iss.last;
         g_lo_ff     <= g_lo_in;
         g_hi_ff     <= g_hi_in;
         last2_ff    <= last1_ff;
         a_lo_ff     <= a_lo_in;
         a_hi_ff     <= a_hi_in;
         last3_ff    <= last2_ff;
         o_lo_ff     <= o_lo_in;
         o_hi_ff     <= o_hi_in;
         out_last_ff <= last3_ff;
      end
   end

endmodule

// ----- tb/dwt_analysis_decimating_filter_bank_tb.sv -----
// ---------------------------------------------------------------------------
// dwt_analysis_decimating_filter_bank_tb
// Feeds sample beats (directed extremes, then random signals of varied
// length, most ended by a last_sample flag) while both channels idle at random. A
// scoreboard runs its own one-level db6 analysis and compares each
// approximation/detail beat in order with the oldest pending coefficient.
// ---------------------------------------------------------------------------
module dwt_analysis_decimating_filter_bank_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dwtdb6_pkg::*;

   // db6 low-pass taps in Q1.14 (4-decimal values times 16384, rounded)
   localparam int DB6_LO_Q14 [12] = '{
      -18, 79, 10, -518, 451, 1597, -2127, -3708, 5166, 12306, 8104, 1827
   };

   typedef struct {
      logic signed [OUT_W-1:0] approx;
      logic signed [OUT_W-1:0] detail;
      logic                    last;
   } coef_pair_type;

   class dwt_coef_scoreboard;
      logic signed [SAMPLE_W-1:0] history [TAPS-1];
      bit                         even_idx;
      coef_pair_type              pending [$];
      int                         errors;

      function new();
         clear_history();
         errors = 0;
      endfunction

      function void clear_history();
         foreach (history[j]) history[j] = '0;
         even_idx = 1'b1;
      endfunction

      function longint lo_coef(int j);
         return (j < 12) ? longint'(DB6_LO_Q14[j]) : 64'sd0;
      endfunction

      // mirror rule: odd taps keep the sign, even taps flip it
      function longint hi_coef(int j);
         return (j % 2 == 1) ? lo_coef(TAPS - 1 - j) : -lo_coef(TAPS - 1 - j);
      endfunction

      function logic signed [OUT_W-1:0] round_sat(longint acc);
         longint q;
         q = (acc + 64'sd8192) >>> 14;
         if (q > OUT_MAX) q = OUT_MAX;
         if (q < OUT_MIN) q = OUT_MIN;
         return q[OUT_W-1:0];
      endfunction

      function void shift_in(logic signed [SAMPLE_W-1:0] s);
         longint        acc_lo;
         longint        acc_hi;
         coef_pair_type c;
         if (even_idx) begin
            acc_lo = longint'(s) * lo_coef(0);
            acc_hi = longint'(s) * hi_coef(0);
            for (int j = 1; j < TAPS; j++) begin
               acc_lo += longint'(history[j-1]) * lo_coef(j);
               acc_hi += longint'(history[j-1]) * hi_coef(j);
            end
            c.approx = round_sat(acc_lo);
            c.detail = round_sat(acc_hi);
            c.last   = 1'b0;
            pending.push_back(c);
         end
         for (int j = TAPS - 2; j > 0; j--) history[j] = history[j-1];
         history[0] = s;
         even_idx = !even_idx;
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last_sample);
         int first;
         first = pending.size();
         shift_in(s);
         if (last_sample) begin
            // flush with zeros, flag the final tail beat, start a new signal
            repeat (TAPS - 2) shift_in('0);
            if (pending.size() > first) pending[$].last = 1'b1;
            clear_history();
         end
      endfunction

      function void check_result(logic signed [OUT_W-1:0] a, logic signed [OUT_W-1:0] d,
                                 logic l);
         coef_pair_type c;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat, actual approx %0d detail %0d last %0b",
                     $time, a, d, l);
            errors++;
            return;
         end
         c = pending.pop_front();
         if (a !== c.approx) begin
            $display("%0t: approx mismatch, expected %0d, actual %0d", $time, c.approx, a);
            errors++;
         end
         if (d !== c.detail) begin
            $display("%0t: detail mismatch, expected %0d, actual %0d", $time, c.detail, d);
            errors++;
         end
         if (l !== c.last) begin
            $display("%0t: last_output mismatch, expected %0b, actual %0b",
                     $time, c.last, l);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT   = 5000;
   localparam int RANDOM_BEATS  = 350;
   localparam int TAIL_CYCLES   = 20;

   logic clock = 1'b0;
   logic reset;

   int src_idle_pct;
   int rcv_idle_pct;
   int stall_cycles;
   int random_beats;

   dwt_coef_scoreboard sb = new();

   dwtdb6_req_if req_chan ();
   dwtdb6_rsp_if rsp_chan ();

   dwt_analysis_decimating_filter_bank dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic l);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.sample      <= s;
      req_chan.last_sample <= l;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_sample(s, l);
   endtask

   // hold the sender off until every pending coefficient has been returned
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2, 3:    return SAMPLE_W'($urandom_range(511) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_random_signal();
      int  len;
      bit  terminated;
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24);
      terminated = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++) begin
         send_beat(rand_sample(), terminated && (i == len - 1));
         random_beats++;
      end
   endtask

   // result side: check accepted beats, then pick ready for the next edge
   initial begin
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            sb.check_result(rsp_chan.approx, rsp_chan.detail, rsp_chan.last_output);
         rsp_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.sample      <= '0;
      req_chan.last_sample <= 1'b0;
      rsp_chan.ready       <= 1'b0;
      stall_cycles         =  0;
      random_beats         =  0;
      src_idle_pct         =  37;
      rcv_idle_pct         =  86;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single-sample signals at both extremes and at zero: one stream beat plus full tail
      send_beat(16'sh7fff, 1'b1);
      send_beat(16'sh8000, 1'b1);
      send_beat('0, 1'b1);
      // last sample at an odd index
      send_beat(16'sh5555, 1'b0);
      send_beat(16'shaaaa, 1'b1);
      // largest magnitude: each sample matches the sign of its tap at index 12
      for (int i = 0; i <= 12; i++) begin
         if (i == 0)
            send_beat('0, 1'b0);
         else
            send_beat((DB6_LO_Q14[12-i] < 0) ? 16'sh8000 : 16'sh7fff, i == 12);
      end
      // back-to-back terminations
      send_beat(16'sh0001, 1'b1);
      send_beat(16'shffff, 1'b1);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               src_idle_pct = 37;
               rcv_idle_pct = 86;
            end
            1: begin
               src_idle_pct = 86;
               rcv_idle_pct = 37;
            end
            default: begin
               src_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         while (random_beats < (RANDOM_BEATS * (phase + 1)) / 3) send_random_signal();
         // close any open signal so its tail is flushed
         send_beat(rand_sample(), 1'b1);
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/dwtdb6_pkg.sv
hw/rtl/dwtdb6_if.sv
hw/rtl/dwtdb6_front.sv
hw/rtl/dwtdb6_seq.sv
hw/rtl/dwtdb6_mac.sv
hw/rtl/dwt_analysis_decimating_filter_bank.sv
tb/dwt_analysis_decimating_filter_bank_tb.sv
